[rtl/fbc_pkg.sv]
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths, register map, types and helpers of the frustum box culler.
// ----------------------------------------------------------------------------
package fbc_pkg;

	// matrix entry width, plane count
	localparam int COEF_BITS   = 16;
	localparam int PLANE_COUNT = 6;
	localparam int FRAC_BITS   = 12;

	// derived datapath widths
	localparam int COEF_W = COEF_BITS + 1;
	localparam int ORG_W  = 24;
	localparam int CRD_W  = ORG_W + 1;
	localparam int PROD_W = COEF_W + CRD_W;
	localparam int DIST_W = PROD_W + 2;
	localparam int TAG_W  = 16;

	// register port geometry
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int REG_IDX_W = 3;
	localparam int REG_LSB   = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROW_ZERO  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROW_ONE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW_TWO   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROW_THREE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_EXTENT_X  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_EXTENT_Y  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_EXTENT_Z  = 3'd6;

	// reset values of the extents
	localparam logic [7:0] EXTENT_X_RST = 8'd16;
	localparam logic [9:0] EXTENT_Y_RST = 10'd256;
	localparam logic [7:0] EXTENT_Z_RST = 8'd16;

	typedef logic signed [COEF_BITS-1:0] entry_t;
	typedef logic signed [COEF_W-1:0]    coef_t;
	typedef logic signed [CRD_W-1:0]     crd_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [3:0][DATA_W-1:0] row;
		logic [7:0]             extent_x;
		logic [9:0]             extent_y;
		logic [7:0]             extent_z;
	} fbc_cfg_t;

	// box corners, axis 0 is x
	typedef struct packed {
		crd_t [2:0] lo;
		crd_t [2:0] hi;
	} fbc_box_t;

	// matrix entry of one column, bits past the row read as zero
	function automatic entry_t get_entry(input logic [DATA_W-1:0] row,
	                                     input int unsigned col);
		logic [2*DATA_W-1:0] wide;
		wide = {{DATA_W{1'b0}}, row} >> (col * COEF_BITS);
		return entry_t'(wide[COEF_BITS-1:0]);
	endfunction

endpackage

[rtl/fbc_if.sv]
// ----------------------------------------------------------------------------
// fbc channel interfaces
// Valid/ready channels for chunk items in and culling results out.
// ----------------------------------------------------------------------------

// chunk item channel
interface fbc_in_if
	import fbc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [ORG_W-1:0] origin_x;
	logic signed [ORG_W-1:0] origin_y;
	logic signed [ORG_W-1:0] origin_z;
	logic [TAG_W-1:0]        chunk_tag;

	modport source (output valid, output origin_x, output origin_y, output origin_z,
	                output chunk_tag, input ready);
	modport sink (input valid, input origin_x, input origin_y, input origin_z,
	              input chunk_tag, output ready);
endinterface

// result item channel
interface fbc_out_if
	import fbc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [TAG_W-1:0] result_tag;
	logic             visible;

	modport source (output valid, output result_tag, output visible, input ready);
	modport sink (input valid, input result_tag, input visible, output ready);
endinterface

[rtl/fbc_cfg.sv]
// ----------------------------------------------------------------------------
// fbc_cfg
// APB register file: matrix rows and chunk extents.
// ----------------------------------------------------------------------------
module fbc_cfg
	import fbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output fbc_cfg_t          cfg
);

	fbc_cfg_t             cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[REG_LSB +: REG_IDX_W];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row      <= '0;
			cfg_q.extent_x <= EXTENT_X_RST;
			cfg_q.extent_y <= EXTENT_Y_RST;
			cfg_q.extent_z <= EXTENT_Z_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ROW_ZERO:  cfg_q.row[0]   <= pwdata;
				REG_ROW_ONE:   cfg_q.row[1]   <= pwdata;
				REG_ROW_TWO:   cfg_q.row[2]   <= pwdata;
				REG_ROW_THREE: cfg_q.row[3]   <= pwdata;
				REG_EXTENT_X:  cfg_q.extent_x <= pwdata[7:0];
				REG_EXTENT_Y:  cfg_q.extent_y <= pwdata[9:0];
				REG_EXTENT_Z:  cfg_q.extent_z <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_ROW_ZERO:  prdata = cfg_q.row[0];
			REG_ROW_ONE:   prdata = cfg_q.row[1];
			REG_ROW_TWO:   prdata = cfg_q.row[2];
			REG_ROW_THREE: prdata = cfg_q.row[3];
			REG_EXTENT_X:  prdata = DATA_W'(cfg_q.extent_x);
			REG_EXTENT_Y:  prdata = DATA_W'(cfg_q.extent_y);
			REG_EXTENT_Z:  prdata = DATA_W'(cfg_q.extent_z);
			default:       prdata = '0;
		endcase
	end

endmodule

[rtl/fbc_plane_test.sv]
// ----------------------------------------------------------------------------
// fbc_plane_test
// One frustum plane: forms row3 +/- row, picks the far corner, tests sign.
// ----------------------------------------------------------------------------
module fbc_plane_test
	import fbc_pkg::*;
(
	input  logic [DATA_W-1:0] row_three,
	input  logic [DATA_W-1:0] row_src,
	input  logic              minus,
	input  fbc_box_t          box,
	output logic              outside
);

	coef_t                    pl [4];
	logic signed [PROD_W-1:0] prod [3];
	logic signed [DIST_W-1:0] plane_dist;

	// plane coefficients, exact in COEF_W bits
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (minus) begin
				pl[c] = coef_t'(get_entry(row_three, c)) - coef_t'(get_entry(row_src, c));
			end else begin
				pl[c] = coef_t'(get_entry(row_three, c)) + coef_t'(get_entry(row_src, c));
			end
		end
	end

	// far corner along the normal, zero counts as non-negative
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (pl[a][COEF_W-1]) begin
				prod[a] = PROD_W'(pl[a]) * PROD_W'($signed(box.lo[a]));
			end else begin
				prod[a] = PROD_W'(pl[a]) * PROD_W'($signed(box.hi[a]));
			end
		end
	end

	// plane distance in units of 2^-12
	assign plane_dist = DIST_W'(prod[0]) + DIST_W'(prod[1]) + DIST_W'(prod[2])
	                  + DIST_W'(pl[3]);
	assign outside = plane_dist[DIST_W-1];

endmodule

[rtl/frustum_box_cull.sv]
// ----------------------------------------------------------------------------
// frustum_box_cull
// Culls axis-aligned chunk boxes against six view frustum planes.
// ----------------------------------------------------------------------------
// path: an accepted item goes to the input register, then the result register
// throughput: one item per cycle while the sink is ready, held by both registers
// the six plane tests run in parallel between the two registers
// reset: pipeline empties, matrix rows clear, extents go to 16/256/16
// ----------------------------------------------------------------------------
module frustum_box_cull
	import fbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	fbc_in_if.sink            in_ch,
	fbc_out_if.source         out_ch
);

	fbc_cfg_t         cfg;
	fbc_box_t         box_in;
	fbc_box_t         box_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             valid_s1;
	logic [TAG_W-1:0] tag_s2;
	logic             vis_s2;
	logic             valid_s2;
	logic             in_take;
	logic             load_s2;
	logic [PLANE_COUNT-1:0] outside;

	// register file
	fbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// flow control
	assign load_s2     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || load_s2;
	assign in_take     = in_ch.valid && in_ch.ready;

	// box corners from origin and extents
	always_comb begin
		box_in.lo[0] = crd_t'(in_ch.origin_x);
		box_in.lo[1] = crd_t'(in_ch.origin_y);
		box_in.lo[2] = crd_t'(in_ch.origin_z);
		box_in.hi[0] = crd_t'(in_ch.origin_x) + crd_t'($signed({1'b0, cfg.extent_x}));
		box_in.hi[1] = crd_t'(in_ch.origin_y) + crd_t'($signed({1'b0, cfg.extent_y}));
		box_in.hi[2] = crd_t'(in_ch.origin_z) + crd_t'($signed({1'b0, cfg.extent_z}));
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			box_s1 <= box_in;
			tag_s1 <= in_ch.chunk_tag;
		end
	end

	// plane tests, planes are row3+row0, row3-row0, ... row3-row2
	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		fbc_plane_test u_plane (
			.row_three (cfg.row[3]),
			.row_src   (cfg.row[(p / 2) % 3]),
			.minus     (1'((p % 2) != 0)),
			.box       (box_s1),
			.outside   (outside[p])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			tag_s2 <= tag_s1;
			vis_s2 <= ~|outside;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.result_tag = tag_s2;
	assign out_ch.visible    = vis_s2;

	// stalled input only when both stages are full and the sink holds off
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && valid_s2 && !out_ch.ready)
		else $error("input stalled without a full pipeline");

	// an item moved out of the input register shows up as the result
	assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> out_ch.valid && out_ch.result_tag == $past(tag_s1))
		else $error("result tag lost between stages");

	// an accepted item not drained lands in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted item dropped");

	// an all-zero matrix puts every box on every plane
	assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && cfg.row == '0 |=> out_ch.visible)
		else $error("box culled by degenerate planes");

endmodule
